// File: rtl/core/rpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpt_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_ADDR_BITS   = 16;
  localparam int SRC_W           = 16;
  localparam int COUNT_OUT_W     = 5;

  localparam logic KIND_COOR  = 1'b1;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    OUT_FULL      = 3'd0,
    OUT_NO_CHANGE = 3'd1,
    OUT_UPDATED   = 3'd2,
    OUT_INSERTED  = 3'd3,
    OUT_REMOVED   = 3'd4,
    OUT_NOT_FOUND = 3'd5
  } outcome_t;

  typedef struct packed {
    logic             cmd;
    logic [SRC_W-1:0] src_addr;
    logic             node_kind;
    logic [7:0]       signal_level;
    logic [7:0]       hop_rank;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             outcome;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   best_valid;
    logic [SRC_W-1:0]       best_src;
    logic                   best_kind;
    logic [7:0]             best_signal;
    logic [7:0]             best_rank;
  } out_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] signal;
    logic [7:0] rank;
  } slot_info_t;

  typedef struct packed {
    logic cmp;
    logic commit;
    logic ins;
    logic del;
  } rpt_ctl_t;

  typedef struct packed {
    logic valid;
    logic kept;
    logic dbefore;
    logic adv;
  } rpt_link_t;

  function automatic logic ranks_above(slot_info_t a, slot_info_t b);
    logic r;
    if (a.kind != b.kind) begin
      r = (a.kind == KIND_COOR);
    end else if (a.kind == KIND_COOR) begin
      r = (a.signal > b.signal);
    end else begin
      r = (a.rank < b.rank);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rpt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rpt_cell
  import rpt_pkg::*;
#(
  parameter int KEY_W = DEF_ADDR_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rpt_ctl_t         ctl,
  input  wire logic [KEY_W-1:0] cmd_key,
  input  wire slot_info_t       cmd_info,
  input  wire rpt_link_t        left_link,
  input  wire logic [KEY_W-1:0] left_key,
  input  wire slot_info_t       left_info,
  input  wire rpt_link_t        right_link,
  input  wire logic [KEY_W-1:0] right_key,
  input  wire slot_info_t       right_info,
  input  wire logic             pre_in,
  output rpt_link_t             link_o,
  output logic [KEY_W-1:0]      key_o,
  output slot_info_t            info_o,
  output logic                  pre_out,
  output logic                  same_o,
  output logic                  valid_nxt_o,
  output logic [KEY_W-1:0]      key_nxt_o,
  output slot_info_t            info_nxt_o
);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  slot_info_t       info_r;
  logic             match_r;
  logic             above_r;
  logic             same_r;

  logic             valid_nxt;
  logic [KEY_W-1:0] key_nxt;
  slot_info_t       info_nxt;
  logic             stay;
  logic             from_l;
  logic             from_r;
  logic             take_new;

  always_comb begin
    link_o.valid   = valid_r;
    link_o.kept    = valid_r && !(ctl.del && match_r);
    link_o.dbefore = ctl.del && pre_in;
    link_o.adv     = ctl.ins && above_r;
  end

  assign pre_out = pre_in | match_r;
  assign same_o  = same_r;
  assign key_o   = key_r;
  assign info_o  = info_r;

  assign stay   = link_o.kept && (link_o.dbefore == link_o.adv);
  assign from_l = left_link.kept && !left_link.dbefore && left_link.adv;
  assign from_r = right_link.kept && right_link.dbefore && !right_link.adv;

  always_comb begin
    case ({ctl.ins, ctl.del})
      2'b10:   valid_nxt = left_link.valid;
      2'b01:   valid_nxt = right_link.valid;
      default: valid_nxt = valid_r;
    endcase
  end

  assign take_new = ctl.ins && valid_nxt && !(stay || from_l || from_r);

  always_comb begin
    key_nxt  = key_r;
    info_nxt = info_r;
    if (stay) begin
      key_nxt  = key_r;
      info_nxt = info_r;
    end else if (from_l) begin
      key_nxt  = left_key;
      info_nxt = left_info;
    end else if (from_r) begin
      key_nxt  = right_key;
      info_nxt = right_info;
    end else if (take_new) begin
      key_nxt  = cmd_key;
      info_nxt = cmd_info;
    end
  end

  assign valid_nxt_o = valid_nxt;
  assign key_nxt_o   = key_nxt;
  assign info_nxt_o  = info_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.commit) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      key_r  <= key_nxt;
      info_r <= info_nxt;
    end
    if (ctl.cmp) begin
      match_r <= valid_r && (key_r == cmd_key);
      above_r <= ranks_above(cmd_info, info_r);
      same_r  <= valid_r && (key_r == cmd_key) && (info_r == cmd_info);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ranked_parent_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item is compared across the cell row in ST_CMP; in ST_UPD, which waits
// out an output stall, every cell loads from itself, a neighbor or the offered entry,
// the result beat is registered and the next item may be taken (else only when idle).
// Reset: synchronous active-low rst_n empties the table and the output register.
module ranked_parent_table_top
  import rpt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int KEY_W = (ADDR_BITS < SRC_W) ? ADDR_BITS : SRC_W;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  in_item_t         item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;

  rpt_ctl_t         ctl;
  logic             in_accept;
  logic             commit;
  logic             found;
  logic             same_any;
  logic             full;
  outcome_t         outcome;
  logic [KEY_W-1:0] cmd_key;
  slot_info_t       cmd_info;

  rpt_link_t        link   [TABLE_DEPTH];
  logic [KEY_W-1:0] key    [TABLE_DEPTH];
  slot_info_t       info   [TABLE_DEPTH];
  rpt_link_t        l_link [TABLE_DEPTH];
  logic [KEY_W-1:0] l_key  [TABLE_DEPTH];
  slot_info_t       l_info [TABLE_DEPTH];
  rpt_link_t        r_link [TABLE_DEPTH];
  logic [KEY_W-1:0] r_key  [TABLE_DEPTH];
  slot_info_t       r_info [TABLE_DEPTH];
  logic             pre    [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] same_vec;
  logic             vnxt   [TABLE_DEPTH];
  logic [KEY_W-1:0] knxt   [TABLE_DEPTH];
  slot_info_t       inxt   [TABLE_DEPTH];

  assign cmd_key       = item_r.src_addr[KEY_W-1:0];
  assign cmd_info.kind   = item_r.node_kind;
  assign cmd_info.signal = item_r.signal_level;
  assign cmd_info.rank   = item_r.hop_rank;

  assign pre[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign l_link[i] = '{valid: 1'b1, kept: 1'b0, dbefore: 1'b0, adv: 1'b0};
      assign l_key[i]  = '0;
      assign l_info[i] = '0;
    end else begin : g_mid_l
      assign l_link[i] = link[i-1];
      assign l_key[i]  = key[i-1];
      assign l_info[i] = info[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign r_link[i] = '{valid: 1'b0, kept: 1'b0, dbefore: 1'b0, adv: 1'b0};
      assign r_key[i]  = '0;
      assign r_info[i] = '0;
    end else begin : g_mid_r
      assign r_link[i] = link[i+1];
      assign r_key[i]  = key[i+1];
      assign r_info[i] = info[i+1];
    end

    rpt_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .cmd_key     (cmd_key),
      .cmd_info    (cmd_info),
      .left_link   (l_link[i]),
      .left_key    (l_key[i]),
      .left_info   (l_info[i]),
      .right_link  (r_link[i]),
      .right_key   (r_key[i]),
      .right_info  (r_info[i]),
      .pre_in      (pre[i]),
      .link_o      (link[i]),
      .key_o       (key[i]),
      .info_o      (info[i]),
      .pre_out     (pre[i+1]),
      .same_o      (same_vec[i]),
      .valid_nxt_o (vnxt[i]),
      .key_nxt_o   (knxt[i]),
      .info_nxt_o  (inxt[i])
    );
  end

  assign found    = pre[TABLE_DEPTH];
  assign same_any = |same_vec;
  assign full     = link[TABLE_DEPTH-1].valid;

  always_comb begin
    ctl.cmp    = (state_r == ST_CMP);
    ctl.commit = commit;
    ctl.ins    = 1'b0;
    ctl.del    = 1'b0;
    if (item_r.cmd == CMD_REMOVE) begin
      ctl.del = found;
      outcome = found ? OUT_REMOVED : OUT_NOT_FOUND;
    end else if (found && same_any) begin
      outcome = OUT_NO_CHANGE;
    end else if (found) begin
      ctl.ins = 1'b1;
      ctl.del = 1'b1;
      outcome = OUT_UPDATED;
    end else if (full) begin
      outcome = OUT_FULL;
    end else begin
      ctl.ins = 1'b1;
      outcome = OUT_INSERTED;
    end
  end

  assign commit    = (state_r == ST_UPD) && (!out_valid_r || !out_stall);
  assign in_stall  = !((state_r == ST_IDLE) || commit);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = in_accept ? ST_CMP : ST_IDLE;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (commit) begin
          state_nxt = in_accept ? ST_CMP : ST_IDLE;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins && !ctl.del) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del && !ctl.ins) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt.outcome     = outcome;
    out_nxt.entry_count = COUNT_OUT_W'(count_nxt);
    out_nxt.best_valid  = vnxt[0];
    out_nxt.best_src    = '0;
    out_nxt.best_kind   = 1'b0;
    out_nxt.best_signal = '0;
    out_nxt.best_rank   = '0;
    if (vnxt[0]) begin
      out_nxt.best_src    = SRC_W'(knxt[0]);
      out_nxt.best_kind   = inxt[0].kind;
      out_nxt.best_signal = inxt[0].signal;
      out_nxt.best_rank   = inxt[0].rank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    if (commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: verif/ranked_parent_table_top_tb.sv
`timescale 1ns / 1ps
module ranked_parent_table_top_tb;
  import rpt_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int POOL = 24;
  localparam int STALL_LIMIT = 4000;
  localparam logic CMD_OFFER = 1'b0;
  localparam logic KIND_SENSOR = 1'b0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  in_item_t queued_requests[$];
  out_item_t predicted_replies[$];

  logic [15:0] nb_src[DEPTH];
  logic nb_kind[DEPTH];
  logic [7:0] nb_signal[DEPTH];
  logic [7:0] nb_rank[DEPTH];
  int nb_count = 0;

  logic [15:0] addr_pool[POOL];
  logic pool_seen[POOL];
  logic pool_kind[POOL];
  logic [7:0] pool_signal[POOL];
  logic [7:0] pool_rank[POOL];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  logic in_took = 1'b0;

  ranked_parent_table_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic beats_slot(logic kind, logic [7:0] sig, logic [7:0] rank, int i);
    if (kind != nb_kind[i]) begin
      return kind == KIND_COOR;
    end
    if (kind == KIND_COOR) begin
      return sig > nb_signal[i];
    end
    return rank < nb_rank[i];
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < nb_count; i++) begin
      nb_src[i] = nb_src[i + 1];
      nb_kind[i] = nb_kind[i + 1];
      nb_signal[i] = nb_signal[i + 1];
      nb_rank[i] = nb_rank[i + 1];
    end
    nb_count--;
  endfunction

  function automatic void place_sorted(in_item_t it);
    int pos;
    pos = 0;
    while (pos < nb_count && !beats_slot(it.node_kind, it.signal_level, it.hop_rank, pos)) begin
      pos++;
    end
    for (int i = nb_count; i > pos; i--) begin
      nb_src[i] = nb_src[i - 1];
      nb_kind[i] = nb_kind[i - 1];
      nb_signal[i] = nb_signal[i - 1];
      nb_rank[i] = nb_rank[i - 1];
    end
    nb_src[pos] = it.src_addr;
    nb_kind[pos] = it.node_kind;
    nb_signal[pos] = it.signal_level;
    nb_rank[pos] = it.hop_rank;
    nb_count++;
  endfunction

  function automatic out_item_t table_update(in_item_t it);
    out_item_t res;
    int pos;
    res = '0;
    pos = 0;
    while (pos < nb_count && nb_src[pos] != it.src_addr) begin
      pos++;
    end
    if (it.cmd == CMD_REMOVE) begin
      if (pos < nb_count) begin
        drop_slot(pos);
        res.outcome = OUT_REMOVED;
      end else begin
        res.outcome = OUT_NOT_FOUND;
      end
    end else if (pos < nb_count) begin
      if (nb_kind[pos] == it.node_kind && nb_signal[pos] == it.signal_level &&
          nb_rank[pos] == it.hop_rank) begin
        res.outcome = OUT_NO_CHANGE;
      end else begin
        drop_slot(pos);
        place_sorted(it);
        res.outcome = OUT_UPDATED;
      end
    end else if (nb_count >= DEPTH) begin
      res.outcome = OUT_FULL;
    end else begin
      place_sorted(it);
      res.outcome = OUT_INSERTED;
    end
    res.entry_count = COUNT_OUT_W'(nb_count);
    if (nb_count > 0) begin
      res.best_valid = 1'b1;
      res.best_src = nb_src[0];
      res.best_kind = nb_kind[0];
      res.best_signal = nb_signal[0];
      res.best_rank = nb_rank[0];
    end
    return res;
  endfunction

  function automatic in_item_t make_item(logic cmd, logic [15:0] src, logic kind,
                                         logic [7:0] sig, logic [7:0] rank);
    in_item_t it;
    it.cmd = cmd;
    it.src_addr = src;
    it.node_kind = kind;
    it.signal_level = sig;
    it.hop_rank = rank;
    return it;
  endfunction

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", fname, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= queued_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    logic moved;
    moved = 1'b0;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(table_update(in_data));
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (predicted_replies.size() == 0) begin
          $error("result beat with no prediction waiting: %0h", out_data);
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("outcome", 16'(want.outcome), 16'(out_data.outcome));
          check_field("entry_count", 16'(want.entry_count), 16'(out_data.entry_count));
          check_field("best_valid", 16'(want.best_valid), 16'(out_data.best_valid));
          check_field("best_src", want.best_src, out_data.best_src);
          check_field("best_kind", 16'(want.best_kind), 16'(out_data.best_kind));
          check_field("best_signal", 16'(want.best_signal), 16'(out_data.best_signal));
          check_field("best_rank", 16'(want.best_rank), 16'(out_data.best_rank));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** ranked_parent_table_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic queue_random(int count, int remove_pct);
    int idx;
    logic cmd;
    logic kind;
    logic [15:0] src;
    logic [7:0] sig;
    logic [7:0] rank;
    for (int n = 0; n < count; n++) begin
      idx = $urandom_range(POOL - 1);
      src = ($urandom_range(99) < 90) ? addr_pool[idx] : 16'($urandom_range(16'hFFFF));
      cmd = ($urandom_range(99) < remove_pct) ? CMD_REMOVE : CMD_OFFER;
      kind = 1'($urandom_range(1));
      sig = ($urandom_range(99) < 30) ? 8'(120 + $urandom_range(3)) : 8'($urandom_range(255));
      rank = ($urandom_range(99) < 30) ? 8'(40 + $urandom_range(3)) : 8'($urandom_range(255));
      if (cmd == CMD_OFFER && src == addr_pool[idx]) begin
        if (pool_seen[idx] && $urandom_range(99) < 20) begin
          kind = pool_kind[idx];
          sig = pool_signal[idx];
          rank = pool_rank[idx];
        end
        pool_seen[idx] = 1'b1;
        pool_kind[idx] = kind;
        pool_signal[idx] = sig;
        pool_rank[idx] = rank;
      end
      queued_requests.push_back(make_item(cmd, src, kind, sig, rank));
    end
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || in_valid || predicted_replies.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(int sender_idle, int receiver_stall);
    send_idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int b = 0; b < 5; b++) begin
      queue_random(100, (b % 2 == 0) ? 22 : 60);
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) begin
      addr_pool[i] = 16'($urandom_range(16'hFFFF));
      pool_seen[i] = 1'b0;
    end
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    send_idle_pct = 33;
    stall_pct = 48;

    queued_requests.push_back(make_item(CMD_REMOVE, 16'h1234, KIND_COOR, 8'hFF, 8'hFF));
    queued_requests.push_back(make_item(CMD_OFFER, 16'h0000, KIND_SENSOR, 8'h00, 8'hFF));
    queued_requests.push_back(make_item(CMD_OFFER, 16'hFFFF, KIND_COOR, 8'hFF, 8'h00));
    queued_requests.push_back(make_item(CMD_OFFER, 16'h0000, KIND_SENSOR, 8'h00, 8'hFF));
    queued_requests.push_back(make_item(CMD_OFFER, 16'h0001, KIND_SENSOR, 8'h7F, 8'hFF));
    queued_requests.push_back(make_item(CMD_OFFER, 16'h0002, KIND_COOR, 8'hFF, 8'h80));
    queued_requests.push_back(make_item(CMD_OFFER, 16'h0003, KIND_SENSOR, 8'h55, 8'h00));
    queued_requests.push_back(make_item(CMD_OFFER, 16'h0004, KIND_COOR, 8'h00, 8'hAA));
    queued_requests.push_back(make_item(CMD_OFFER, 16'h0000, KIND_COOR, 8'hC8, 8'hFF));
    queued_requests.push_back(make_item(CMD_REMOVE, 16'hFFFF, KIND_SENSOR, 8'h00, 8'h00));
    for (int i = 0; i < 11; i++) begin
      queued_requests.push_back(make_item(CMD_OFFER, 16'h0100 + 16'(i), 1'(i),
                                          8'(i * 23), 8'(255 - i * 20)));
    end
    queued_requests.push_back(make_item(CMD_OFFER, 16'hABCD, KIND_COOR, 8'hFF, 8'h00));
    queued_requests.push_back(make_item(CMD_OFFER, 16'h0101, KIND_COOR, 8'hFF, 8'h00));
    queued_requests.push_back(make_item(CMD_REMOVE, 16'h0100, KIND_COOR, 8'hFF, 8'hFF));
    queued_requests.push_back(make_item(CMD_REMOVE, 16'h0100, KIND_SENSOR, 8'h00, 8'h00));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();

    run_phase(33, 48);
    run_phase(48, 33);
    run_phase(0, 0);
    repeat (8) @(posedge clk);

    if (errors == 0 && predicted_replies.size() == 0) begin
      $display("** ranked_parent_table_top: PASSED **");
    end else begin
      $display("** ranked_parent_table_top: FAILED **");
    end
    $finish;
  end

endmodule
